### hdl/hva_pkg.sv
// Shared opcode, status and classification types for the homogeneous vector ALU.
package hva_pkg;

   localparam int FUNC_W   = 4;
   localparam int STATUS_W = 3;

   typedef enum logic [FUNC_W-1:0] {
      FN_ADD   = 4'd0,
      FN_SUB   = 4'd1,
      FN_NEG   = 4'd2,
      FN_SCALE = 4'd3,
      FN_DIV   = 4'd4,
      FN_MAG   = 4'd5,
      FN_NORM  = 4'd6,
      FN_DOT   = 4'd7,
      FN_CROSS = 4'd8
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK          = 3'd0,
      ST_TWO_PTS     = 3'd1,
      ST_PT_FROM_VEC = 3'd2,
      ST_DIV_ZERO    = 3'd3,
      ST_SAT         = 3'd4
   } status_type;

   // What the front end learns about an item before it is queued.
   typedef struct packed {
      func_type op;
      logic     two_pts;
      logic     pt_from_vec;
      logic     div_zero;
   } class_type;

endpackage

### hdl/hva_if.sv
// Valid/ready channel interfaces for the request and response items.
interface hva_req_if #(parameter int W = 32) ();
   logic                 valid;
   logic                 ready;
   logic [3:0]           func;
   logic signed [W-1:0]  a_x;
   logic signed [W-1:0]  a_y;
   logic signed [W-1:0]  a_z;
   logic signed [W-1:0]  a_w;
   logic signed [W-1:0]  b_x;
   logic signed [W-1:0]  b_y;
   logic signed [W-1:0]  b_z;
   logic signed [W-1:0]  b_w;
   logic signed [W-1:0]  scalar_in;

   modport source (output valid, func, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, scalar_in,
                   input ready);
   modport sink (input valid, func, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, scalar_in,
                 output ready);
endinterface

interface hva_rsp_if #(parameter int W = 32) ();
   logic                 valid;
   logic                 ready;
   logic signed [W-1:0]  r_x;
   logic signed [W-1:0]  r_y;
   logic signed [W-1:0]  r_z;
   logic signed [W-1:0]  r_w;
   logic signed [W-1:0]  scalar_out;
   logic [2:0]           status;

   modport source (output valid, r_x, r_y, r_z, r_w, scalar_out, status, input ready);
   modport sink (input valid, r_x, r_y, r_z, r_w, scalar_out, status, output ready);
endinterface

### hdl/homogeneous_vector_alu.sv
// Top level of the homogeneous vector ALU: front end, queue and execution pipeline.
//
// Vector unit on homogeneous (x,y,z,w) tuples in signed fixed point with COMPONENT_WIDTH
// bit components and FRACTION_BITS fraction bits. Every request item gives exactly one
// response item, in order. The unit takes one item per clock cycle while responses are
// taken and keeps that rate whatever mix of operations arrives; the defaults give Q16.16.
// Each item passes from acceptance through the queue, the multiplier stage and the adder
// stage, then COMPONENT_WIDTH stages of the square-root pipeline (one root bit per stage),
// then COMPONENT_WIDTH + FRACTION_BITS stages of the four divider lanes (one quotient bit
// per stage), then the response register. Every operation passes through all of these
// stages so that results leave in order. A two-item queue sits between the front end and
// the pipeline; when a response waits at the output, the pipeline holds as a whole and the
// front end keeps taking items until the queue is full.
module homogeneous_vector_alu import hva_pkg::*; #(
   parameter int COMPONENT_WIDTH = 32,
   parameter int FRACTION_BITS   = 16
) (
   input  logic      clock,
   input  logic      reset,
   hva_req_if.sink   req_ch,
   hva_rsp_if.source rsp_ch
);

   localparam int DW = 9 * COMPONENT_WIDTH;

   // Front end to queue.
   logic          push;
   logic          q_full;
   class_type     f_cls;
   logic [DW-1:0] f_data;

   // Queue to execution pipeline.
   logic          pop;
   logic          q_empty;
   class_type     q_cls;
   logic [DW-1:0] q_data;

   hva_front #(.W(COMPONENT_WIDTH), .F(FRACTION_BITS)) u_front (
      .req    (req_ch),
      .q_full (q_full),
      .push   (push),
      .cls    (f_cls),
      .data   (f_data)
   );

   hva_queue #(.DW(DW)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .in_cls   (f_cls),
      .in_data  (f_data),
      .full     (q_full),
      .pop      (pop),
      .empty    (q_empty),
      .out_cls  (q_cls),
      .out_data (q_data)
   );

   hva_back #(.W(COMPONENT_WIDTH), .F(FRACTION_BITS)) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .pop     (pop),
      .in_cls  (q_cls),
      .in_data (q_data),
      .rsp     (rsp_ch)
   );

endmodule

### hdl/hva_queue.sv
// Two-entry queue between the classifying front end and the execution pipeline.
module hva_queue import hva_pkg::*; #(
   parameter int DW = 288
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  class_type     in_cls,
   input  logic [DW-1:0] in_data,
   output logic          full,
   input  logic          pop,
   output logic          empty,
   output class_type     out_cls,
   output logic [DW-1:0] out_data
);

   localparam int DEPTH = 2;

   class_type     ent_cls_ff  [DEPTH];
   logic [DW-1:0] ent_data_ff [DEPTH];
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    count_ff, count_in;

   assign full     = (count_ff == 2'(DEPTH));
   assign empty    = (count_ff == 2'd0);
   assign out_cls  = ent_cls_ff[rd_ptr_ff];
   assign out_data = ent_data_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_cls_ff[wr_ptr_ff]  <= in_cls;
         ent_data_ff[wr_ptr_ff] <= in_data;
      end
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'(DEPTH))
      else $error("queue count beyond depth");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != 2'd0)
      else $error("queue popped while empty");
`endif

endmodule

### hdl/hva_front.sv
// Front end: accepts request items, checks the w rules and divisor, and queues them.
module hva_front import hva_pkg::*; #(
   parameter int W = 32,
   parameter int F = 16
) (
   hva_req_if.sink       req,
   input  logic          q_full,
   output logic          push,
   output class_type     cls,
   output logic [9*W-1:0] data
);

   localparam int SW = W + F + 2;
   localparam logic signed [SW-1:0] TWO_ONE = SW'(2) << F;

   logic signed [SW-1:0] w_sum;
   logic signed [SW-1:0] w_diff;

   assign req.ready = !q_full;
   assign push      = req.valid && !q_full;

   always_comb begin
      w_sum  = {{(SW-W){req.a_w[W-1]}}, req.a_w} + {{(SW-W){req.b_w[W-1]}}, req.b_w};
      w_diff = {{(SW-W){req.a_w[W-1]}}, req.a_w} - {{(SW-W){req.b_w[W-1]}}, req.b_w};
      cls.op          = func_type'(req.func);
      cls.two_pts     = (w_sum == TWO_ONE);
      cls.pt_from_vec = w_diff[SW-1];
      cls.div_zero    = (req.scalar_in == '0);
      data = {req.scalar_in, req.b_w, req.b_z, req.b_y, req.b_x,
              req.a_w, req.a_z, req.a_y, req.a_x};
   end

endmodule

### hdl/hva_sqrt.sv
// Pipelined floor square root, one root bit per stage.
module hva_sqrt #(
   parameter int W = 32
) (
   input  logic           clock,
   input  logic           en,
   input  logic [2*W-1:0] rad,
   output logic [W-1:0]   root
);

   localparam int RW = W + 3;

   logic [RW-1:0]  rem_ff [W];
   logic [W-1:0]   q_ff   [W];
   logic [2*W-1:0] rd_ff  [W];

   genvar k;
   generate
      for (k = 0; k < W; k++) begin : g_step
         logic [RW-1:0]  rem_prev;
         logic [W-1:0]   q_prev;
         logic [2*W-1:0] rd_prev;
         logic [RW-1:0]  shifted;
         logic [RW-1:0]  trial;

         if (k == 0) begin : g_first
            assign rem_prev = '0;
            assign q_prev   = '0;
            assign rd_prev  = rad;
         end else begin : g_next
            assign rem_prev = rem_ff[k-1];
            assign q_prev   = q_ff[k-1];
            assign rd_prev  = rd_ff[k-1];
         end

         assign shifted = {rem_prev[RW-3:0], rd_prev[2*W-1 -: 2]};
         assign trial   = {1'b0, q_prev, 2'b01};

         always_ff @(posedge clock) begin
            if (en) begin
               if (shifted >= trial) begin
                  rem_ff[k] <= shifted - trial;
                  q_ff[k]   <= {q_prev[W-2:0], 1'b1};
               end else begin
                  rem_ff[k] <= shifted;
                  q_ff[k]   <= {q_prev[W-2:0], 1'b0};
               end
               rd_ff[k] <= {rd_prev[2*W-3:0], 2'b00};
            end
         end
      end
   endgenerate

   assign root = q_ff[W-1];

endmodule

### hdl/hva_div.sv
// Pipelined restoring divider lane, one quotient bit per stage.
module hva_div #(
   parameter int W = 32,
   parameter int F = 16
) (
   input  logic           clock,
   input  logic           en,
   input  logic [W+F-1:0] dividend,
   input  logic [W-1:0]   divisor,
   output logic [W+F-1:0] quot
);

   localparam int N = W + F;

   logic [W-1:0] rem_ff [N];
   logic [N-1:0] x_ff   [N];
   logic [W-1:0] d_ff   [N];

   genvar k;
   generate
      for (k = 0; k < N; k++) begin : g_step
         logic [W-1:0] rem_prev;
         logic [N-1:0] x_prev;
         logic [W-1:0] d_prev;
         logic [W:0]   trial;
         logic [W:0]   diff;
         logic         ge;

         if (k == 0) begin : g_first
            assign rem_prev = '0;
            assign x_prev   = dividend;
            assign d_prev   = divisor;
         end else begin : g_next
            assign rem_prev = rem_ff[k-1];
            assign x_prev   = x_ff[k-1];
            assign d_prev   = d_ff[k-1];
         end

         assign trial = {rem_prev, x_prev[N-1]};
         assign diff  = trial - {1'b0, d_prev};
         assign ge    = (trial >= {1'b0, d_prev});

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k] <= ge ? diff[W-1:0] : trial[W-1:0];
               x_ff[k]   <= {x_prev[N-2:0], ge};
               d_ff[k]   <= d_prev;
            end
         end
      end
   endgenerate

   assign quot = x_ff[N-1];

endmodule

### hdl/hva_back.sv
// Execution pipeline: multipliers, sums and clamps, square root, dividers, response register.
module hva_back import hva_pkg::*; #(
   parameter int W = 32,
   parameter int F = 16
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           q_empty,
   output logic           pop,
   input  class_type      in_cls,
   input  logic [9*W-1:0] in_data,
   hva_rsp_if.source      rsp
);

   localparam int N  = W + F;
   localparam int CW = (2*W + 2 > W + F + 2) ? 2*W + 2 : W + F + 2;
   localparam int L  = 2 + W + N;
   localparam logic signed [CW-1:0] MAXC = {{(CW-W+1){1'b0}}, {(W-1){1'b1}}};
   localparam logic signed [CW-1:0] MINC = {{(CW-W+1){1'b1}}, {(W-1){1'b0}}};

   typedef struct packed {
      class_type             cls;
      logic [3:0][W-1:0]     a;
      logic [3:0][W-1:0]     b;
      logic [W-1:0]          s;
   } s1_type;

   typedef struct packed {
      func_type              op;
      status_type            status;
      logic [3:0][W-1:0]     r;
      logic [W-1:0]          sc;
      logic [3:0]            neg;
      logic [3:0][W-1:0]     absa;
      logic [W-1:0]          root;
   } side_type;

   function automatic logic signed [CW-1:0] ext_c(input logic [W-1:0] v);
      ext_c = {{(CW-W){v[W-1]}}, v};
   endfunction

   function automatic logic signed [CW-1:0] ext_p(input logic [2*W-1:0] v);
      ext_p = {{(CW-2*W){v[2*W-1]}}, v};
   endfunction

   function automatic logic signed [CW-1:0] ext_q(input logic [N-1:0] q, input logic neg);
      logic signed [CW-1:0] t;
      t = {{(CW-N){1'b0}}, q};
      ext_q = neg ? -t : t;
   endfunction

   // Returns the saturation flag above the clamped component.
   function automatic logic [W:0] clampw(input logic signed [CW-1:0] v);
      if (v > MAXC) begin
         clampw = {1'b1, MAXC[W-1:0]};
      end else if (v < MINC) begin
         clampw = {1'b1, MINC[W-1:0]};
      end else begin
         clampw = {1'b0, v[W-1:0]};
      end
   endfunction

   logic                  adv;
   logic [L-1:0]          vchain_ff, vchain_in;

   s1_type                s1_ff, s1_in;
   logic signed [W-1:0]   mx [6];
   logic signed [W-1:0]   my [6];
   logic [2*W-1:0]        prod_ff [6];
   logic [2*W-1:0]        prod_in [6];

   logic signed [W-1:0]   av [4];
   logic signed [W-1:0]   bv [4];
   logic signed [CW-1:0]  dot_sum;
   logic signed [CW-1:0]  sq_sum;
   logic signed [CW-1:0]  cr_diff [3];
   logic [W:0]            cl2 [4];
   logic                  sat2;
   side_type              side2_ff, side2_in;
   logic [2*W-1:0]        sumsq_ff, sumsq_in;

   side_type              sq_side_ff [W];
   side_type              sq_exit;
   logic [W-1:0]          root_w;
   side_type              dv_side_ff [N];
   logic [N-1:0]          quot [4];
   side_type              fs;
   logic [W:0]            clf [4];
   logic                  fsat;

   logic [3:0][W-1:0]     out_r;
   logic [W-1:0]          out_sc;
   status_type            out_status;
   logic                  rsp_valid_ff;
   logic [3:0][W-1:0]     rsp_r_ff;
   logic [W-1:0]          rsp_sc_ff;
   status_type            rsp_status_ff;

   // The whole pipeline moves as one whenever the response register can take a value.
   assign adv       = !rsp_valid_ff || rsp.ready;
   assign pop       = adv && !q_empty;
   assign vchain_in = {vchain_ff[L-2:0], pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         vchain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vchain_ff    <= vchain_in;
         rsp_valid_ff <= vchain_ff[L-1];
      end
   end

   // Stage one: operand selection and the six multipliers.
   always_comb begin
      s1_in.cls = in_cls;
      s1_in.a   = in_data[4*W-1:0];
      s1_in.b   = in_data[8*W-1:4*W];
      s1_in.s   = in_data[9*W-1:8*W];
      for (int k = 0; k < 6; k++) begin
         mx[k] = '0;
         my[k] = '0;
      end
      unique case (in_cls.op) inside
         FN_SCALE: begin
            for (int k = 0; k < 4; k++) begin
               mx[k] = $signed(s1_in.a[k]);
               my[k] = $signed(s1_in.s);
            end
         end
         FN_MAG, FN_NORM: begin
            for (int k = 0; k < 3; k++) begin
               mx[k] = $signed(s1_in.a[k]);
               my[k] = $signed(s1_in.a[k]);
            end
         end
         FN_DOT: begin
            for (int k = 0; k < 3; k++) begin
               mx[k] = $signed(s1_in.a[k]);
               my[k] = $signed(s1_in.b[k]);
            end
         end
         FN_CROSS: begin
            mx[0] = $signed(s1_in.a[1]); my[0] = $signed(s1_in.b[2]);
            mx[1] = $signed(s1_in.a[2]); my[1] = $signed(s1_in.b[1]);
            mx[2] = $signed(s1_in.a[2]); my[2] = $signed(s1_in.b[0]);
            mx[3] = $signed(s1_in.a[0]); my[3] = $signed(s1_in.b[2]);
            mx[4] = $signed(s1_in.a[0]); my[4] = $signed(s1_in.b[1]);
            mx[5] = $signed(s1_in.a[1]); my[5] = $signed(s1_in.b[0]);
         end
         default: ;
      endcase
      for (int k = 0; k < 6; k++) begin
         prod_in[k] = mx[k] * my[k];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff <= s1_in;
         for (int k = 0; k < 6; k++) begin
            prod_ff[k] <= prod_in[k];
         end
      end
   end

   // Stage two: sums, shifts and clamps for everything that needs no root or quotient.
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         av[i]  = $signed(s1_ff.a[i]);
         bv[i]  = $signed(s1_ff.b[i]);
         cl2[i] = '0;
      end
      dot_sum = ext_p(prod_ff[0]) + ext_p(prod_ff[1]) + ext_p(prod_ff[2]);
      sq_sum  = dot_sum;
      cr_diff[0] = ext_p(prod_ff[0]) - ext_p(prod_ff[1]);
      cr_diff[1] = ext_p(prod_ff[2]) - ext_p(prod_ff[3]);
      cr_diff[2] = ext_p(prod_ff[4]) - ext_p(prod_ff[5]);
      sumsq_in = sq_sum[2*W-1:0];
      sat2 = 1'b0;

      side2_in.op     = s1_ff.cls.op;
      side2_in.status = ST_OK;
      side2_in.r      = '0;
      side2_in.sc     = '0;
      side2_in.root   = s1_ff.s[W-1] ? W'(0) - s1_ff.s : s1_ff.s;
      for (int i = 0; i < 4; i++) begin
         side2_in.absa[i] = av[i][W-1] ? W'(0) - s1_ff.a[i] : s1_ff.a[i];
         side2_in.neg[i]  = (s1_ff.cls.op == FN_DIV) ? (av[i][W-1] ^ s1_ff.s[W-1])
                                                     : av[i][W-1];
      end

      case (s1_ff.cls.op)
         FN_ADD: begin
            if (s1_ff.cls.two_pts) begin
               side2_in.status = ST_TWO_PTS;
            end else begin
               for (int i = 0; i < 4; i++) begin
                  cl2[i] = clampw(ext_c(av[i]) + ext_c(bv[i]));
                  side2_in.r[i] = cl2[i][W-1:0];
                  sat2 = sat2 | cl2[i][W];
               end
            end
         end
         FN_SUB: begin
            if (s1_ff.cls.pt_from_vec) begin
               side2_in.status = ST_PT_FROM_VEC;
            end else begin
               for (int i = 0; i < 4; i++) begin
                  cl2[i] = clampw(ext_c(av[i]) - ext_c(bv[i]));
                  side2_in.r[i] = cl2[i][W-1:0];
                  sat2 = sat2 | cl2[i][W];
               end
            end
         end
         FN_NEG: begin
            for (int i = 0; i < 4; i++) begin
               cl2[i] = clampw(-ext_c(av[i]));
               side2_in.r[i] = cl2[i][W-1:0];
               sat2 = sat2 | cl2[i][W];
            end
         end
         FN_SCALE: begin
            for (int i = 0; i < 4; i++) begin
               cl2[i] = clampw(ext_p(prod_ff[i]) >>> F);
               side2_in.r[i] = cl2[i][W-1:0];
               sat2 = sat2 | cl2[i][W];
            end
         end
         FN_DIV: begin
            // A zero divisor drives every non-zero component to the limit of its sign.
            if (s1_ff.cls.div_zero) begin
               side2_in.status = ST_DIV_ZERO;
               for (int i = 0; i < 4; i++) begin
                  if (s1_ff.a[i] == '0) begin
                     side2_in.r[i] = '0;
                  end else if (av[i][W-1]) begin
                     side2_in.r[i] = MINC[W-1:0];
                  end else begin
                     side2_in.r[i] = MAXC[W-1:0];
                  end
               end
            end
         end
         FN_NORM: begin
            // Kept in case the magnitude turns out to be zero.
            side2_in.r = s1_ff.a;
         end
         FN_DOT: begin
            cl2[0] = clampw(dot_sum >>> F);
            side2_in.sc = cl2[0][W-1:0];
            sat2 = cl2[0][W];
         end
         FN_CROSS: begin
            for (int i = 0; i < 3; i++) begin
               cl2[i] = clampw(cr_diff[i] >>> F);
               side2_in.r[i] = cl2[i][W-1:0];
               sat2 = sat2 | cl2[i][W];
            end
         end
         default: ;
      endcase

      if (side2_in.status == ST_OK && sat2) begin
         side2_in.status = ST_SAT;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side2_ff <= side2_in;
         sumsq_ff <= sumsq_in;
      end
   end

   // Square root stages, with the item's side data travelling alongside.
   hva_sqrt #(.W(W)) u_sqrt (
      .clock (clock),
      .en    (adv),
      .rad   (sumsq_ff),
      .root  (root_w)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_side_ff[0] <= side2_ff;
         for (int k = 1; k < W; k++) begin
            sq_side_ff[k] <= sq_side_ff[k-1];
         end
      end
   end

   // From here on the root field is the divisor: |scalar| for divide, the magnitude otherwise.
   always_comb begin
      sq_exit = sq_side_ff[W-1];
      if (sq_exit.op != FN_DIV) begin
         sq_exit.root = root_w;
      end
   end

   genvar g;
   generate
      for (g = 0; g < 4; g++) begin : g_lane
         hva_div #(.W(W), .F(F)) u_div (
            .clock    (clock),
            .en       (adv),
            .dividend ({sq_exit.absa[g], {F{1'b0}}}),
            .divisor  (sq_exit.root),
            .quot     (quot[g])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_side_ff[0] <= sq_exit;
         for (int k = 1; k < N; k++) begin
            dv_side_ff[k] <= dv_side_ff[k-1];
         end
      end
   end

   // Final stage: sign and clamp the quotients or the magnitude, or pass the earlier result.
   assign fs = dv_side_ff[N-1];

   always_comb begin
      out_r      = fs.r;
      out_sc     = fs.sc;
      out_status = fs.status;
      fsat       = 1'b0;
      for (int i = 0; i < 4; i++) begin
         clf[i] = '0;
      end
      case (fs.op)
         FN_MAG: begin
            if (fs.root[W-1]) begin
               out_sc     = MAXC[W-1:0];
               out_status = ST_SAT;
            end else begin
               out_sc     = fs.root;
               out_status = ST_OK;
            end
         end
         FN_NORM: begin
            if (fs.root != '0) begin
               for (int i = 0; i < 3; i++) begin
                  clf[i]   = clampw(ext_q(quot[i], fs.neg[i]));
                  out_r[i] = clf[i][W-1:0];
                  fsat     = fsat | clf[i][W];
               end
               out_r[3]   = '0;
               out_status = fsat ? ST_SAT : ST_OK;
            end
         end
         FN_DIV: begin
            if (fs.status != ST_DIV_ZERO) begin
               for (int i = 0; i < 4; i++) begin
                  clf[i]   = clampw(ext_q(quot[i], fs.neg[i]));
                  out_r[i] = clf[i][W-1:0];
                  fsat     = fsat | clf[i][W];
               end
               out_status = fsat ? ST_SAT : ST_OK;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_r_ff      <= out_r;
         rsp_sc_ff     <= out_sc;
         rsp_status_ff <= out_status;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.r_x        = rsp_r_ff[0];
   assign rsp.r_y        = rsp_r_ff[1];
   assign rsp.r_z        = rsp_r_ff[2];
   assign rsp.r_w        = rsp_r_ff[3];
   assign rsp.scalar_out = rsp_sc_ff;
   assign rsp.status     = rsp_status_ff;

`ifndef ASSERT_OFF
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_status_ff <= ST_SAT)
      else $error("response status out of range");
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff == ST_TWO_PTS || rsp_status_ff == ST_PT_FROM_VEC)
      |-> rsp_r_ff == '0 && rsp_sc_ff == '0)
      else $error("rejected item returned a non-zero result");
`endif

endmodule
